// ----- hdl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master register sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam logic [7:0] ADDR_RESET = 8'h90;

    typedef enum logic [1:0] {
        REQ_READ     = 2'd0,
        REQ_WRITE    = 2'd1,
        REQ_XFER     = 2'd2,
        REQ_ARB_LOST = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_START_SEND   = 3'd1,
        ACT_SEND         = 3'd2,
        ACT_RESTART_SEND = 3'd3,
        ACT_RECEIVE      = 3'd4,
        ACT_RECEIVE_NACK = 3'd5,
        ACT_STOP         = 3'd6
    } t_action;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_SEND_REG  = 7'b0000010,
        PH_SEND_DATA = 7'b0000100,
        PH_RESTART   = 7'b0001000,
        PH_DUMMY     = 7'b0010000,
        PH_READ      = 7'b0100000,
        PH_STOP      = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_req       req;
        logic [7:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        t_action    action;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       done;
        logic       busy;
    } t_out_word;

endpackage

// ----- hdl/i2c_master_register_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer_unit
// Byte-level I2C master sequencer for single-register reads and writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one event word: a read or
//   write request, a byte-complete event or an arbitration loss. Each word
//   produces exactly one result word on the output channel (o_valid /
//   i_stall): the bus action to issue, the byte to send, the last captured
//   read byte and done / busy flags.
//   The device address register is written through i_cfg_valid / i_cfg_data;
//   o_cfg_ready is always high. Write it only while the block is idle.
//   Path from input accept to o_valid: one input register, then the sequencer
//   step into the result register. Throughput is one word per cycle while
//   i_stall is low; the sequencer state is updated in the same cycle the result
//   register loads, so consecutive words chain without bubbles.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word if it is empty; o_stall rises
//   only while the input register is full and cannot move.
//   Synchronous reset (i_rst_n low) empties both registers, returns the
//   sequencer to idle, clears the held bytes and loads address 0x90.
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer_unit
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // event input
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_reg_index,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_rx_byte,
    // result output
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_bus_action,
    output logic [7:0] o_tx_byte,
    output logic [7:0] o_read_data,
    output logic       o_done_res,
    output logic       o_busy_res,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;

    logic [7:0] r_dev_addr;
    t_phase     r_phase;
    logic       r_is_read;
    logic [7:0] r_held_reg;
    logic [7:0] r_held_wdata;
    logic [7:0] r_captured;

    t_phase     n_phase;
    logic       n_is_read;
    logic [7:0] n_held_reg;
    logic [7:0] n_held_wdata;
    logic [7:0] n_captured;
    t_out_word  n_out;

    logic       out_blocked;
    logic       step;
    logic       in_load;

    assign out_blocked = r_out_valid && i_stall;
    assign step        = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;
    assign in_load     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // sequencer step
    always_comb begin
        n_phase      = r_phase;
        n_is_read    = r_is_read;
        n_held_reg   = r_held_reg;
        n_held_wdata = r_held_wdata;
        n_captured   = r_captured;
        n_out.action  = ACT_NONE;
        n_out.tx_byte = 8'h00;
        n_out.done    = 1'b0;
        case (r_in.req)
            REQ_READ, REQ_WRITE: begin
                n_is_read  = (r_in.req == REQ_READ);
                n_held_reg = r_in.reg_index;
                if (r_in.req == REQ_WRITE) begin
                    n_held_wdata = r_in.write_data;
                end
                n_out.action  = ACT_START_SEND;
                n_out.tx_byte = r_dev_addr;
                n_phase       = PH_SEND_REG;
            end
            REQ_ARB_LOST: begin
                n_phase = PH_IDLE;
            end
            default: begin
                case (r_phase)
                    PH_SEND_REG: begin
                        n_out.action  = ACT_SEND;
                        n_out.tx_byte = r_held_reg;
                        n_phase       = r_is_read ? PH_RESTART : PH_SEND_DATA;
                    end
                    PH_SEND_DATA: begin
                        n_out.action  = ACT_SEND;
                        n_out.tx_byte = r_held_wdata;
                        n_phase       = PH_STOP;
                    end
                    PH_RESTART: begin
                        n_out.action  = ACT_RESTART_SEND;
                        n_out.tx_byte = r_dev_addr | 8'h01;
                        n_phase       = PH_DUMMY;
                    end
                    PH_DUMMY: begin
                        n_out.action = ACT_RECEIVE;
                        n_phase      = PH_READ;
                    end
                    PH_READ: begin
                        n_out.action = ACT_RECEIVE_NACK;
                        n_captured   = r_in.rx_byte;
                        n_phase      = PH_STOP;
                    end
                    PH_STOP: begin
                        n_out.action = ACT_STOP;
                        n_out.done   = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        endcase
        n_out.read_data = n_captured;
        n_out.busy      = (n_phase != PH_IDLE);
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dev_addr   <= ADDR_RESET;
            r_phase      <= PH_IDLE;
            r_is_read    <= 1'b0;
            r_held_reg   <= 8'h00;
            r_held_wdata <= 8'h00;
            r_captured   <= 8'h00;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_dev_addr <= i_cfg_data;
            end
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_is_read    <= n_is_read;
                r_held_reg   <= n_held_reg;
                r_held_wdata <= n_held_wdata;
                r_captured   <= n_captured;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in.req        <= t_req'(i_req_type);
            r_in.reg_index  <= i_reg_index;
            r_in.write_data <= i_write_data;
            r_in.rx_byte    <= i_rx_byte;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bus_action = r_out.action;
    assign o_tx_byte    = r_out.tx_byte;
    assign o_read_data  = r_out.read_data;
    assign o_done_res   = r_out.done;
    assign o_busy_res   = r_out.busy;

    // checks
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !(o_bus_action == ACT_START_SEND || o_bus_action == ACT_SEND ||
                     o_bus_action == ACT_RESTART_SEND) |-> o_tx_byte == 8'h00)
        else $error("tx byte nonzero on a non-send action");

    a_done_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_bus_action == ACT_STOP)
        else $error("done without stop action");

    a_arb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in.req == REQ_ARB_LOST |=> r_phase == PH_IDLE && !o_busy_res)
        else $error("arbitration loss did not return to idle");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room to take a word");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master register sequencer unit.
// Every event word sent into the block is stepped through a local model of
// the read/write sequence; each result word must match the oldest prediction.
// The stimulus begins with directed sequences: field extremes, restart while
// busy, arbitration loss and events while idle. Random well-formed reads and
// writes follow, mixed with broken sequences and noise. The device address is
// rewritten between phases, and random gaps and stalls fall on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 12;
    localparam int PIPE_LATENCY   = 2;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_EVENTS   = 105;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_req_type = '0;
    logic [7:0] i_reg_index = '0;
    logic [7:0] i_write_data = '0;
    logic [7:0] i_rx_byte = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_bus_action;
    logic [7:0] o_tx_byte;
    logic [7:0] o_read_data;
    logic       o_done_res;
    logic       o_busy_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    i2c_master_register_sequencer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_bus_action (o_bus_action),
        .o_tx_byte    (o_tx_byte),
        .o_read_data  (o_read_data),
        .o_done_res   (o_done_res),
        .o_busy_res   (o_busy_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Sequencer model state
    logic [7:0] dev_addr = ADDR_RESET;
    t_phase     seq_phase = PH_IDLE;
    logic       seq_is_read = 1'b0;
    logic [7:0] seq_reg = '0;
    logic [7:0] seq_wdata = '0;
    logic [7:0] seq_rdata = '0;

    t_in_word   pending_events[$];
    t_out_word  expected_results[$];

    bit          no_idle = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned planned_events = 0;
    int unsigned accepted_events = 0;
    int unsigned checked_results = 0;
    int unsigned done_count = 0;
    int unsigned addr_settings = 1;
    int unsigned failures = 0;
    int unsigned quiet_cycles = 0;

    function automatic t_out_word sequence_step(t_in_word w);
        t_out_word r;
        r.action  = ACT_NONE;
        r.tx_byte = '0;
        r.done    = 1'b0;
        case (w.req)
            REQ_READ, REQ_WRITE: begin
                seq_is_read = (w.req == REQ_READ);
                seq_reg     = w.reg_index;
                if (!seq_is_read)
                    seq_wdata = w.write_data;
                r.action  = ACT_START_SEND;
                r.tx_byte = dev_addr;
                seq_phase = PH_SEND_REG;
            end
            REQ_ARB_LOST: seq_phase = PH_IDLE;
            default: begin
                case (seq_phase)
                    PH_SEND_REG: begin
                        r.action  = ACT_SEND;
                        r.tx_byte = seq_reg;
                        seq_phase = seq_is_read ? PH_RESTART : PH_SEND_DATA;
                    end
                    PH_SEND_DATA: begin
                        r.action  = ACT_SEND;
                        r.tx_byte = seq_wdata;
                        seq_phase = PH_STOP;
                    end
                    PH_RESTART: begin
                        r.action  = ACT_RESTART_SEND;
                        r.tx_byte = dev_addr | 8'h01;
                        seq_phase = PH_DUMMY;
                    end
                    PH_DUMMY: begin
                        // dummy read: received byte is thrown away
                        r.action  = ACT_RECEIVE;
                        seq_phase = PH_READ;
                    end
                    PH_READ: begin
                        r.action  = ACT_RECEIVE_NACK;
                        seq_rdata = w.rx_byte;
                        seq_phase = PH_STOP;
                    end
                    PH_STOP: begin
                        r.action  = ACT_STOP;
                        r.done    = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    default: seq_phase = PH_IDLE;
                endcase
            end
        endcase
        r.read_data = seq_rdata;
        r.busy      = (seq_phase != PH_IDLE);
        return r;
    endfunction

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Driver: present queued words, hold while stalled, random gaps between words
    always @(posedge i_clk) begin
        t_in_word w;
        bit       fire;
        if (i_rst_n) begin
            fire = i_valid && !o_stall;
            if (fire) begin
                w = '{req: t_req'(i_req_type), reg_index: i_reg_index,
                      write_data: i_write_data, rx_byte: i_rx_byte};
                expected_results.push_back(sequence_step(w));
                accepted_events++;
            end
            if (i_valid && !fire) begin
                // hold the stalled word
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_events.size() > 0) begin
                w = pending_events.pop_front();
                i_req_type   <= w.req;
                i_reg_index  <= w.reg_index;
                i_write_data <= w.write_data;
                i_rx_byte    <= w.rx_byte;
                i_valid      <= 1'b1;
                gap_left     <= draw_wait();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            failures++;
        end
    endtask

    // Monitor: check each accepted result word, stall at random after each word
    always @(posedge i_clk) begin
        t_out_word   exp_word;
        int unsigned n;
        if (i_rst_n) begin
            if (i_stall) begin
                stall_left <= stall_left - 1;
                i_stall    <= (stall_left > 1);
            end else if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no prediction pending");
                    failures++;
                end else begin
                    exp_word = expected_results.pop_front();
                    check_field("bus_action", exp_word.action, o_bus_action);
                    check_field("tx_byte", exp_word.tx_byte, o_tx_byte);
                    check_field("read_data", exp_word.read_data, o_read_data);
                    check_field("done_res", exp_word.done, o_done_res);
                    check_field("busy_res", exp_word.busy, o_busy_res);
                    checked_results++;
                    if (exp_word.done)
                        done_count++;
                end
                n = draw_wait();
                stall_left <= n;
                i_stall    <= (n != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_event(input t_req req, input logic [7:0] reg_num,
                              input logic [7:0] wdata, input logic [7:0] rx,
                              input bit counted = 1'b1);
        pending_events.push_back('{req: req, reg_index: reg_num,
                                   write_data: wdata, rx_byte: rx});
        if (counted)
            planned_events++;
    endtask

    task automatic push_xfer(input logic [7:0] rx);
        push_event(REQ_XFER, rand_byte(), rand_byte(), rx);
    endtask

    task automatic push_write_seq(input logic [7:0] reg_num, input logic [7:0] wdata);
        push_event(REQ_WRITE, reg_num, wdata, rand_byte());
        repeat (3) push_xfer(rand_byte());
    endtask

    task automatic push_read_seq(input logic [7:0] reg_num, input logic [7:0] dummy_rx,
                                 input logic [7:0] data_rx);
        push_event(REQ_READ, reg_num, rand_byte(), rand_byte());
        push_xfer(rand_byte());
        push_xfer(dummy_rx);
        push_xfer(rand_byte());
        push_xfer(data_rx);
        push_xfer(rand_byte());
    endtask

    // Wait until the block has answered everything, then let the pipe settle
    task automatic drain_results();
        while (pending_events.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_device_address(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        dev_addr = value;
        i_cfg_valid <= 1'b0;
        addr_settings++;
    endtask

    task automatic push_random_phase();
        int unsigned start_count;
        int unsigned pick;
        int unsigned k;
        start_count = planned_events;
        while (planned_events - start_count < PHASE_EVENTS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                push_write_seq(rand_byte(), rand_byte());
            end else if (pick <= 7) begin
                push_read_seq(rand_byte(), rand_byte(), rand_byte());
            end else if (pick == 8) begin
                // broken sequence: cut short by arbitration loss or a new request
                push_event(t_req'($urandom_range(0, 1)), rand_byte(),
                           rand_byte(), rand_byte());
                k = $urandom_range(0, 3);
                repeat (k) push_xfer(rand_byte());
                case ($urandom_range(0, 2))
                    0: push_event(REQ_ARB_LOST, rand_byte(), rand_byte(), rand_byte());
                    1: push_event(t_req'($urandom_range(0, 1)), rand_byte(),
                                  rand_byte(), rand_byte());
                    default: ;
                endcase
            end else begin
                push_event(t_req'($urandom_range(0, 3)), rand_byte(),
                           rand_byte(), rand_byte(), 1'b0);
            end
        end
    endtask

    initial begin
        logic [7:0] addr_list[4];
        addr_list = '{8'h00, 8'hFE, 8'h55, 8'h90};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle events, field extremes, restart while busy, arbitration loss
        push_event(REQ_XFER, 8'hFF, 8'hFF, 8'hFF);
        push_event(REQ_ARB_LOST, 8'h00, 8'h00, 8'h00);
        push_write_seq(8'h00, 8'hFF);
        push_write_seq(8'hFF, 8'h00);
        push_read_seq(8'hFF, 8'h00, 8'hFF);
        push_event(REQ_WRITE, 8'h3C, 8'hC3, 8'h00);
        push_read_seq(8'h00, 8'hFF, 8'h00);
        push_event(REQ_READ, 8'h81, 8'h7E, 8'h00);
        push_xfer(8'hFF);
        push_event(REQ_ARB_LOST, 8'hFF, 8'hFF, 8'hFF);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_device_address(p < 4 ? addr_list[p] : 8'($urandom_range(0, 254)));
            no_idle = (p == 2 || p == 4);
            push_random_phase();
            drain_results();
        end

        $display("Covered %0d event words and %0d result words, %0d stop pulses,",
                 accepted_events, checked_results, done_count);
        $display("over %0d device address settings with random gaps and stalls.",
                 addr_settings);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/i2cms_pkg.sv
hdl/i2c_master_register_sequencer_unit.sv
tb/sv/tb_top.sv
